### hdl/partitioned_membership_table_assert.svh
// Assertion helpers for the membership table. They expect clk and rst_n in scope.
`ifndef PARTITIONED_MEMBERSHIP_TABLE_ASSERT_SVH
`define PARTITIONED_MEMBERSHIP_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMT_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMT_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/pmt_pkg.sv
package pmt_pkg;

  // Table geometry.
  localparam int MOL_MAX   = 1024;
  localparam int BOX_COUNT = 2;
  localparam int KIND_MAX  = 8;

  localparam int MOL_W     = $clog2(MOL_MAX);
  localparam int CNT_W     = $clog2(MOL_MAX + 1);
  localparam int SEC_DEPTH = BOX_COUNT * KIND_MAX + 1;
  localparam int SEC_IW    = $clog2(SEC_DEPTH);

  // Fixed field widths of the channels.
  localparam int FUNC_W = 3;
  localparam int KIND_W = 3;
  localparam int BOX_W  = 1;
  localparam int NK_W   = 4;
  localparam int STS_W  = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_COUNT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;
  localparam logic [STS_W-1:0] STS_RANGE     = 2'd3;

  // Update command for the section start table.
  typedef struct packed {
    logic              clear;
    logic              inc_en;
    logic [SEC_IW-1:0] inc_lo;
    logic [SEC_IW-1:0] inc_hi;
    logic              wr_en;
    logic [SEC_IW-1:0] wr_idx;
    logic [CNT_W-1:0]  wr_data;
  } pmt_sec_cmd_t;

endpackage

### hdl/pmt_if.sv
// Input item channel.
interface pmt_in_if;
  import pmt_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [MOL_W-1:0]  mol_id;
  logic [BOX_W-1:0]  box;
  logic [BOX_W-1:0]  to_box;
  logic [KIND_W-1:0] kind;
  logic [MOL_W-1:0]  offset;

  modport source (output valid, func, mol_id, box, to_box, kind, offset, input ready);
  modport sink (input valid, func, mol_id, box, to_box, kind, offset, output ready);
endinterface

// Result item channel.
interface pmt_out_if;
  import pmt_pkg::*;
  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [MOL_W-1:0] found_mol;
  logic [CNT_W-1:0] kind_count;
  logic [CNT_W-1:0] box_count;

  modport source (output valid, status, found_mol, kind_count, box_count, input ready);
  modport sink (input valid, status, found_mol, kind_count, box_count, output ready);
endinterface

// Register write channel.
interface pmt_cfg_if;
  import pmt_pkg::*;
  logic            valid;
  logic            ready;
  logic [NK_W-1:0] num_kinds;

  modport source (output valid, num_kinds, input ready);
  modport sink (input valid, num_kinds, output ready);
endinterface

### hdl/pmt_sec_table.sv
module pmt_sec_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pmt_pkg::pmt_sec_cmd_t       cmd,
  input  logic [pmt_pkg::SEC_IW-1:0]  rd_idx,
  output logic [pmt_pkg::CNT_W-1:0]   rd_data
);
  import pmt_pkg::*;

  logic [CNT_W-1:0] sec_start_r [SEC_DEPTH];

  // Each section start updates on its own: clear, direct write, or range increment.
  always_ff @(posedge clk) begin
    for (int s = 0; s < SEC_DEPTH; s++) begin
      if (!rst_n || cmd.clear) begin
        sec_start_r[s] <= '0;
      end else if (cmd.wr_en && (cmd.wr_idx == SEC_IW'(s))) begin
        sec_start_r[s] <= cmd.wr_data;
      end else if (cmd.inc_en && (SEC_IW'(s) >= cmd.inc_lo) && (SEC_IW'(s) <= cmd.inc_hi)) begin
        sec_start_r[s] <= sec_start_r[s] + 1'b1;
      end
    end
  end

  // Single read port; indexes past the table read as zero.
  assign rd_data = (int'(rd_idx) < SEC_DEPTH) ? sec_start_r[rd_idx] : '0;

endmodule

### hdl/partitioned_membership_table.sv
// Channel | Direction | Payload                                   | Transfer when
// in_ch   | sink      | func, mol_id, box, to_box, kind, offset   | valid && ready
// out_ch  | source    | status, found_mol, kind_count, box_count  | valid && ready
// cfg_ch  | sink      | num_kinds                                 | valid && ready
//
// One item is worked at a time; in_ch.ready is high only while the sequencer is idle.
// Append shifts each later entry up by one; move scans its source section entry by entry,
// then crosses one section boundary at a time. The sequence is set by the single read port
// of the section start table and the registered read of the single molecule memory used
// for shifts and swaps.
// Reset clears the section starts, the molecule total and sets num_kinds to 1.
// A finished result waits in the output register; a new item is taken meanwhile.
module partitioned_membership_table (
  input  logic      clk,
  input  logic      rst_n,
  pmt_in_if.sink    in_ch,
  pmt_out_if.source out_ch,
  pmt_cfg_if.sink   cfg_ch
);
  import pmt_pkg::*;

  `include "partitioned_membership_table_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_AP_RD, ST_AP_WR, ST_MV_HI, ST_MV_RD, ST_MV_CMP, ST_MV_STEP,
    ST_MV_RA, ST_MV_RB, ST_MV_WA, ST_MV_WB, ST_CQ1, ST_CQ2, ST_CQ3, ST_RE1, ST_RE2,
    ST_FIN
  } state_t;

  // Sequencer registers.
  state_t            state_r, state_nxt;
  logic [NK_W-1:0]   nk_r, nk_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [MOL_W-1:0]  mol_r, mol_nxt;
  logic [BOX_W-1:0]  box_r, box_nxt;
  logic [BOX_W-1:0]  to_r, to_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [MOL_W-1:0]  off_r, off_nxt;
  logic [SEC_IW-1:0] sec_r, sec_nxt;
  logic [SEC_IW-1:0] target_r, target_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;
  logic [MOL_W-1:0]  cur_r, cur_nxt;
  logic [MOL_W-1:0]  nxt_r, nxt_nxt;
  logic [MOL_W-1:0]  tmp_r, tmp_nxt;
  logic [STS_W-1:0]  sts_r, sts_nxt;
  logic [MOL_W-1:0]  found_r, found_nxt;
  logic [CNT_W-1:0]  kcnt_r, kcnt_nxt;
  logic [CNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]  o_sts_r, o_sts_nxt;
  logic [MOL_W-1:0]  o_found_r, o_found_nxt;
  logic [CNT_W-1:0]  o_kcnt_r, o_kcnt_nxt;
  logic [CNT_W-1:0]  o_bcnt_r, o_bcnt_nxt;

  // Molecule memory.
  logic [MOL_W-1:0] mem [MOL_MAX];
  logic [MOL_W-1:0] mem_rdata_r;
  logic             mem_we;
  logic [MOL_W-1:0] mem_waddr;
  logic [MOL_W-1:0] mem_wdata;
  logic [MOL_W-1:0] mem_raddr;

  // Section table port.
  pmt_sec_cmd_t      sec_cmd;
  logic [SEC_IW-1:0] sec_rd_idx;
  logic [CNT_W-1:0]  sec_rd;

  // Decoded operands.
  logic [SEC_IW-1:0] nk_w;
  logic [SEC_IW-1:0] box_base;
  logic [SEC_IW-1:0] box_end;
  logic [SEC_IW-1:0] sec_cur;
  logic [SEC_IW-1:0] sec_tgt;
  logic              kind_ok;
  logic              box_ok;
  logic              to_ok;
  logic              move_down;
  logic [CNT_W-1:0]  i_dec;
  logic [CNT_W-1:0]  rd_span;
  logic [CNT_W-1:0]  rd_pos;
  logic [NK_W-1:0]   nk_sat;
  logic              cfg_xfer;
  logic              in_xfer;
  logic              out_xfer;

  pmt_sec_table u_sec (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sec_cmd),
    .rd_idx  (sec_rd_idx),
    .rd_data (sec_rd)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = o_sts_r;
  assign out_ch.found_mol  = o_found_r;
  assign out_ch.kind_count = o_kcnt_r;
  assign out_ch.box_count  = o_bcnt_r;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;

  // Section indexes of the captured item.
  assign nk_w      = SEC_IW'(nk_r);
  assign box_base  = box_r ? nk_w : '0;
  assign box_end   = box_base + nk_w;
  assign sec_cur   = box_base + SEC_IW'(kind_r);
  assign sec_tgt   = (to_r ? nk_w : '0) + SEC_IW'(kind_r);
  assign kind_ok   = (NK_W'(kind_r) < nk_r);
  assign box_ok    = (int'(box_r) < BOX_COUNT);
  assign to_ok     = (int'(to_r) < BOX_COUNT);
  assign move_down = (box_r >= to_r);
  assign i_dec     = i_r - 1'b1;
  assign rd_span   = sec_rd - a_r;
  assign rd_pos    = a_r + CNT_W'(off_r);

  // Register value is saturated into the legal kind range.
  always_comb begin
    nk_sat = cfg_ch.num_kinds;
    if (cfg_ch.num_kinds == '0) begin
      nk_sat = NK_W'(1);
    end else if (cfg_ch.num_kinds > NK_W'(KIND_MAX)) begin
      nk_sat = NK_W'(KIND_MAX);
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    nk_nxt        = nk_r;
    total_nxt     = total_r;
    func_nxt      = func_r;
    mol_nxt       = mol_r;
    box_nxt       = box_r;
    to_nxt        = to_r;
    kind_nxt      = kind_r;
    off_nxt       = off_r;
    sec_nxt       = sec_r;
    target_nxt    = target_r;
    i_nxt         = i_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    cur_nxt       = cur_r;
    nxt_nxt       = nxt_r;
    tmp_nxt       = tmp_r;
    sts_nxt       = sts_r;
    found_nxt     = found_r;
    kcnt_nxt      = kcnt_r;
    bcnt_nxt      = bcnt_r;
    out_valid_nxt = out_valid_r;
    o_sts_nxt     = o_sts_r;
    o_found_nxt   = o_found_r;
    o_kcnt_nxt    = o_kcnt_r;
    o_bcnt_nxt    = o_bcnt_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    mem_wdata     = mem_rdata_r;
    mem_raddr     = i_r[MOL_W-1:0];
    sec_cmd       = '0;
    sec_rd_idx    = sec_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    // A register write rebuilds an empty table for the new layout.
    if (cfg_xfer) begin
      nk_nxt        = nk_sat;
      total_nxt     = '0;
      sec_cmd.clear = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          func_nxt  = in_ch.func;
          mol_nxt   = in_ch.mol_id;
          box_nxt   = in_ch.box;
          to_nxt    = in_ch.to_box;
          kind_nxt  = in_ch.kind;
          off_nxt   = in_ch.offset;
          sts_nxt   = STS_OK;
          found_nxt = '0;
          kcnt_nxt  = '0;
          bcnt_nxt  = '0;
          state_nxt = ST_DISP;
        end
      end

      ST_DISP: begin
        state_nxt = ST_FIN;
        unique case (func_r)
          FN_APPEND: begin
            if (!kind_ok || !box_ok) begin
              sts_nxt = STS_RANGE;
            end else if (total_r >= CNT_W'(MOL_MAX)) begin
              sts_nxt = STS_FULL;
            end else begin
              // Insertion point is the end of the section.
              sec_rd_idx = sec_cur + 1'b1;
              hi_nxt     = sec_rd;
              i_nxt      = total_r;
              state_nxt  = ST_AP_RD;
            end
          end
          FN_MOVE: begin
            if (!kind_ok || !box_ok || !to_ok) begin
              sts_nxt = STS_RANGE;
            end else begin
              sec_rd_idx = sec_cur;
              i_nxt      = sec_rd;
              sec_nxt    = sec_cur;
              target_nxt = sec_tgt;
              state_nxt  = ST_MV_HI;
            end
          end
          FN_COUNT: begin
            if (!kind_ok || !box_ok) begin
              sts_nxt = STS_RANGE;
            end else begin
              sec_rd_idx = sec_cur;
              a_nxt      = sec_rd;
              sec_nxt    = sec_cur;
              state_nxt  = ST_CQ1;
            end
          end
          FN_READ: begin
            if (!box_ok) begin
              sts_nxt = STS_RANGE;
            end else begin
              sec_rd_idx = box_base;
              a_nxt      = sec_rd;
              state_nxt  = ST_RE1;
            end
          end
          FN_CLEAR: begin
            sec_cmd.clear = 1'b1;
            total_nxt     = '0;
          end
          default: begin
            sts_nxt = STS_RANGE;
          end
        endcase
      end

      // Append: shift later entries up by one, top down, then insert.
      ST_AP_RD: begin
        if (i_r > hi_r) begin
          mem_raddr = i_dec[MOL_W-1:0];
          state_nxt = ST_AP_WR;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = hi_r[MOL_W-1:0];
          mem_wdata      = mol_r;
          sec_cmd.inc_en = 1'b1;
          sec_cmd.inc_lo = sec_cur + 1'b1;
          sec_cmd.inc_hi = nk_w + nk_w;
          total_nxt      = total_r + 1'b1;
          state_nxt      = ST_FIN;
        end
      end

      ST_AP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_r[MOL_W-1:0];
        mem_wdata = mem_rdata_r;
        i_nxt     = i_dec;
        state_nxt = ST_AP_RD;
      end

      // Move: scan the source section for the molecule.
      ST_MV_HI: begin
        sec_rd_idx = sec_r + 1'b1;
        hi_nxt     = sec_rd;
        state_nxt  = ST_MV_RD;
      end

      ST_MV_RD: begin
        if (i_r < hi_r) begin
          mem_raddr = i_r[MOL_W-1:0];
          state_nxt = ST_MV_CMP;
        end else begin
          sts_nxt   = STS_NOT_FOUND;
          state_nxt = ST_FIN;
        end
      end

      ST_MV_CMP: begin
        if (mem_rdata_r == mol_r) begin
          cur_nxt   = i_r[MOL_W-1:0];
          state_nxt = ST_MV_STEP;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_MV_RD;
        end
      end

      // Move: cross one section boundary and adjust that boundary.
      ST_MV_STEP: begin
        if (sec_r == target_r) begin
          state_nxt = ST_FIN;
        end else begin
          sec_cmd.wr_en = 1'b1;
          if (move_down) begin
            sec_rd_idx      = sec_r;
            sec_cmd.wr_idx  = sec_r;
            sec_cmd.wr_data = sec_rd + 1'b1;
            nxt_nxt         = sec_rd[MOL_W-1:0];
            sec_nxt         = sec_r - 1'b1;
          end else begin
            sec_rd_idx      = sec_r + 1'b1;
            sec_cmd.wr_idx  = sec_r + 1'b1;
            sec_cmd.wr_data = sec_rd - 1'b1;
            nxt_nxt         = MOL_W'(sec_rd - 1'b1);
            sec_nxt         = sec_r + 1'b1;
          end
          state_nxt = ST_MV_RA;
        end
      end

      ST_MV_RA: begin
        mem_raddr = cur_r;
        state_nxt = ST_MV_RB;
      end

      ST_MV_RB: begin
        mem_raddr = nxt_r;
        tmp_nxt   = mem_rdata_r;
        state_nxt = ST_MV_WA;
      end

      ST_MV_WA: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = mem_rdata_r;
        state_nxt = ST_MV_WB;
      end

      ST_MV_WB: begin
        mem_we    = 1'b1;
        mem_waddr = nxt_r;
        mem_wdata = tmp_r;
        cur_nxt   = nxt_r;
        state_nxt = ST_MV_STEP;
      end

      // Count query: section size, then box size.
      ST_CQ1: begin
        sec_rd_idx = sec_r + 1'b1;
        kcnt_nxt   = rd_span;
        state_nxt  = ST_CQ2;
      end

      ST_CQ2: begin
        sec_rd_idx = box_base;
        a_nxt      = sec_rd;
        state_nxt  = ST_CQ3;
      end

      ST_CQ3: begin
        sec_rd_idx = box_end;
        bcnt_nxt   = rd_span;
        state_nxt  = ST_FIN;
      end

      // Entry read: bound the offset by the box size, then fetch.
      ST_RE1: begin
        sec_rd_idx = box_end;
        if (CNT_W'(off_r) >= rd_span) begin
          sts_nxt   = STS_RANGE;
          state_nxt = ST_FIN;
        end else begin
          mem_raddr = rd_pos[MOL_W-1:0];
          hi_nxt    = rd_span;
          state_nxt = ST_RE2;
        end
      end

      ST_RE2: begin
        found_nxt = mem_rdata_r;
        bcnt_nxt  = hi_r;
        state_nxt = ST_FIN;
      end

      // Hand the result to the output register once it is free.
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_sts_nxt     = sts_r;
          o_found_nxt   = found_r;
          o_kcnt_nxt    = kcnt_r;
          o_bcnt_nxt    = bcnt_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nk_r        <= NK_W'(1);
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nk_r        <= nk_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    mol_r     <= mol_nxt;
    box_r     <= box_nxt;
    to_r      <= to_nxt;
    kind_r    <= kind_nxt;
    off_r     <= off_nxt;
    sec_r     <= sec_nxt;
    target_r  <= target_nxt;
    i_r       <= i_nxt;
    hi_r      <= hi_nxt;
    a_r       <= a_nxt;
    cur_r     <= cur_nxt;
    nxt_r     <= nxt_nxt;
    tmp_r     <= tmp_nxt;
    sts_r     <= sts_nxt;
    found_r   <= found_nxt;
    kcnt_r    <= kcnt_nxt;
    bcnt_r    <= bcnt_nxt;
    o_sts_r   <= o_sts_nxt;
    o_found_r <= o_found_nxt;
    o_kcnt_r  <= o_kcnt_nxt;
    o_bcnt_r  <= o_bcnt_nxt;
  end

  // Molecule memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  // Checks on the sequencer.
  `PMT_CHECK_NEXT(a_busy_after_accept, in_xfer, !in_ch.ready, "input taken while busy")
  `PMT_CHECK_NOW(a_total_bound, 1'b1, total_r <= CNT_W'(MOL_MAX), "molecule total overflow")
  `PMT_CHECK_NOW(a_write_busy, mem_we, state_r != ST_IDLE, "memory written while idle")
  `PMT_CHECK_NEXT(a_fin_loads, (state_r == ST_FIN) && (!out_valid_r || out_ch.ready), out_valid_r && in_ch.ready, "result not loaded")

endmodule

### sim/tb_partitioned_membership_table.sv
`timescale 1ns / 1ps

module tb_partitioned_membership_table;
  import pmt_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int CROWD_LIMIT  = 48;
  localparam int PHASE_ITEMS  = 88;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [MOL_W-1:0]  mol_id;
    logic [BOX_W-1:0]  box;
    logic [BOX_W-1:0]  to_box;
    logic [KIND_W-1:0] kind;
    logic [MOL_W-1:0]  offset;
  } op_item_t;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [MOL_W-1:0] found_mol;
    logic [CNT_W-1:0] kind_count;
    logic [CNT_W-1:0] box_count;
  } op_result_t;

  typedef enum logic [1:0] {STEP_OP, STEP_KINDS, STEP_DRAIN} step_sel_e;

  typedef struct {
    step_sel_e        sel;
    op_item_t         op;
    logic [NK_W-1:0]  kinds;
  } stim_step_t;

  // Where the stimulus generator believes each appended molecule sits.
  typedef struct {
    logic [MOL_W-1:0] id;
    int               bx;
    int               kd;
  } placed_t;

  logic clk;
  logic rst_n;

  pmt_in_if  in_ch ();
  pmt_out_if out_ch ();
  pmt_cfg_if cfg_ch ();

  partitioned_membership_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Mirror of the table contents, section starts and kind setting.
  logic [MOL_W-1:0] mirror_store [MOL_MAX];
  logic [CNT_W-1:0] mirror_start [SEC_DEPTH];
  logic [CNT_W-1:0] mirror_total;
  logic [NK_W-1:0]  mirror_kinds;

  stim_step_t pending_steps[$];
  op_result_t expected_results[$];
  placed_t    placed_q[$];
  int         plan_kinds;

  int n_planned;
  int n_sent;
  int n_seen;
  int n_fail;
  int gap_left;
  int stall_left;
  int cycle_count;

  stim_step_t head_step;
  op_item_t   taken_op;
  op_result_t want;
  bit         give_op;
  bit         give_cfg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void table_clear();
    for (int i = 0; i < MOL_MAX; i++) mirror_store[i] = '0;
    for (int i = 0; i < SEC_DEPTH; i++) mirror_start[i] = '0;
    mirror_total = '0;
  endfunction

  // A kinds write saturates into 1..KIND_MAX and empties the table.
  function automatic void table_set_kinds(input logic [NK_W-1:0] val);
    if (val == 0) mirror_kinds = 1;
    else if (val > KIND_MAX) mirror_kinds = KIND_MAX;
    else mirror_kinds = val;
    table_clear();
  endfunction

  // Applies one operation to the mirror and returns the result it produces.
  function automatic op_result_t table_apply(input op_item_t op);
    op_result_t res;
    int nk, nsec, sec, tgt, pos, lo, hi, idx, cur, nxt, base, span;
    bit sec_ok;
    logic [MOL_W-1:0] tmp;
    res = '{default: '0};
    nk = int'(mirror_kinds);
    nsec = BOX_COUNT * nk;
    sec = int'(op.box) * nk + int'(op.kind);
    sec_ok = (op.box < BOX_COUNT) && (op.kind < nk);
    case (op.func)
      FN_APPEND: begin
        if (!sec_ok) begin
          res.status = STS_RANGE;
        end else if (mirror_total >= MOL_MAX) begin
          res.status = STS_FULL;
        end else begin
          // Open a slot at the end of the section by shifting later entries up.
          pos = mirror_start[sec + 1];
          for (idx = mirror_total; idx > pos; idx--) mirror_store[idx] = mirror_store[idx - 1];
          mirror_store[pos] = op.mol_id;
          for (idx = sec + 1; idx <= nsec; idx++) mirror_start[idx] = mirror_start[idx] + 1'b1;
          mirror_total = mirror_total + 1'b1;
        end
      end
      FN_MOVE: begin
        if (!sec_ok || op.to_box >= BOX_COUNT) begin
          res.status = STS_RANGE;
        end else begin
          lo = mirror_start[sec];
          hi = mirror_start[sec + 1];
          idx = lo;
          while (idx < hi && mirror_store[idx] != op.mol_id) idx++;
          if (idx >= hi) begin
            res.status = STS_NOT_FOUND;
          end else begin
            // Carry the molecule one section boundary at a time.
            cur = idx;
            tgt = int'(op.to_box) * nk + int'(op.kind);
            if (op.box >= op.to_box) begin
              while (sec != tgt) begin
                nxt = mirror_start[sec];
                mirror_start[sec] = nxt + 1;
                tmp = mirror_store[cur];
                mirror_store[cur] = mirror_store[nxt];
                mirror_store[nxt] = tmp;
                cur = nxt;
                sec--;
              end
            end else begin
              while (sec != tgt) begin
                sec++;
                mirror_start[sec] = mirror_start[sec] - 1'b1;
                nxt = mirror_start[sec];
                tmp = mirror_store[cur];
                mirror_store[cur] = mirror_store[nxt];
                mirror_store[nxt] = tmp;
                cur = nxt;
              end
            end
          end
        end
      end
      FN_COUNT: begin
        if (!sec_ok) begin
          res.status = STS_RANGE;
        end else begin
          res.kind_count = mirror_start[sec + 1] - mirror_start[sec];
          res.box_count = mirror_start[(int'(op.box) + 1) * nk] - mirror_start[int'(op.box) * nk];
        end
      end
      FN_READ: begin
        if (op.box >= BOX_COUNT) begin
          res.status = STS_RANGE;
        end else begin
          base = mirror_start[int'(op.box) * nk];
          span = int'(mirror_start[(int'(op.box) + 1) * nk]) - base;
          if (op.offset >= span) begin
            res.status = STS_RANGE;
          end else begin
            res.found_mol = mirror_store[base + int'(op.offset)];
            res.box_count = span;
          end
        end
      end
      FN_CLEAR: begin
        table_clear();
      end
      default: begin
        res.status = STS_RANGE;
      end
    endcase
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none in calm stretches.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      n_fail++;
    end
  endtask

  // Queues one operation and tracks where successful appends and moves leave molecules.
  task automatic push_op(input logic [FUNC_W-1:0] fn, input int id, input int bx,
                         input int to_bx, input int kd, input int off);
    stim_step_t st;
    bit hit;
    st.sel = STEP_OP;
    st.kinds = '0;
    st.op.func = fn;
    st.op.mol_id = id;
    st.op.box = bx;
    st.op.to_box = to_bx;
    st.op.kind = kd;
    st.op.offset = off;
    hit = 1'b0;
    case (fn)
      FN_APPEND: begin
        if (kd < plan_kinds && placed_q.size() < MOL_MAX)
          placed_q.push_back('{st.op.mol_id, bx, kd});
      end
      FN_MOVE: begin
        if (kd < plan_kinds) begin
          for (int j = 0; j < placed_q.size() && !hit; j++) begin
            if (placed_q[j].id == st.op.mol_id && placed_q[j].bx == bx && placed_q[j].kd == kd) begin
              placed_q[j].bx = to_bx;
              hit = 1'b1;
            end
          end
        end
      end
      FN_CLEAR: begin
        placed_q.delete();
      end
      default: begin
      end
    endcase
    pending_steps.push_back(st);
    n_planned++;
  endtask

  task automatic push_kinds(input logic [NK_W-1:0] val);
    stim_step_t st;
    st.sel = STEP_KINDS;
    st.op = '{default: '0};
    st.kinds = val;
    pending_steps.push_back(st);
    placed_q.delete();
    if (val == 0) plan_kinds = 1;
    else if (val > KIND_MAX) plan_kinds = KIND_MAX;
    else plan_kinds = val;
  endtask

  task automatic push_drain();
    stim_step_t st;
    st.sel = STEP_DRAIN;
    st.op = '{default: '0};
    st.kinds = '0;
    pending_steps.push_back(st);
  endtask

  // One random operation, biased toward moves of molecules that are really present.
  task automatic push_random_op();
    int r, b, k, n, off, pick;
    logic [FUNC_W-1:0] fn;
    r = $urandom_range(99);
    b = $urandom_range(BOX_COUNT - 1);
    k = $urandom_range(plan_kinds - 1);
    if (placed_q.size() >= CROWD_LIMIT) r = 99;
    if (r < 35) begin
      push_op(FN_APPEND, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1), k,
              $urandom_range(MOL_MAX - 1));
    end else if (r < 60) begin
      if (placed_q.size() != 0 && $urandom_range(4) != 0) begin
        pick = $urandom_range(placed_q.size() - 1);
        push_op(FN_MOVE, placed_q[pick].id, placed_q[pick].bx, $urandom_range(BOX_COUNT - 1),
                placed_q[pick].kd, $urandom_range(MOL_MAX - 1));
      end else begin
        push_op(FN_MOVE, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1), k,
                $urandom_range(MOL_MAX - 1));
      end
    end else if (r < 72) begin
      push_op(FN_COUNT, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1), k,
              $urandom_range(MOL_MAX - 1));
    end else if (r < 88) begin
      n = 0;
      foreach (placed_q[j]) if (placed_q[j].bx == b) n++;
      off = (n != 0 && $urandom_range(5) != 0) ? $urandom_range(n - 1)
                                               : $urandom_range(MOL_MAX - 1);
      push_op(FN_READ, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1),
              $urandom_range(KIND_MAX - 1), off);
    end else if (r < 93) begin
      if (plan_kinds < KIND_MAX) begin
        case ($urandom_range(2))
          0: fn = FN_APPEND;
          1: fn = FN_MOVE;
          default: fn = FN_COUNT;
        endcase
        push_op(fn, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1),
                $urandom_range(KIND_MAX - 1, plan_kinds), $urandom_range(MOL_MAX - 1));
      end else begin
        push_op(FN_COUNT, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1), k,
                $urandom_range(MOL_MAX - 1));
      end
    end else if (r < 96) begin
      push_op($urandom_range((1 << FUNC_W) - 1, FN_CLEAR + 1), $urandom_range(MOL_MAX - 1), b,
              $urandom_range(BOX_COUNT - 1), $urandom_range(KIND_MAX - 1),
              $urandom_range(MOL_MAX - 1));
    end else begin
      push_op(FN_CLEAR, $urandom_range(MOL_MAX - 1), b, $urandom_range(BOX_COUNT - 1),
              $urandom_range(KIND_MAX - 1), $urandom_range(MOL_MAX - 1));
    end
  endtask

  // Stimulus plan, reset and end of run.
  initial begin
    logic [NK_W-1:0] kinds_plan [8];
    int pick;
    in_ch.valid = 1'b0;
    in_ch.func = FN_APPEND;
    in_ch.mol_id = '0;
    in_ch.box = '0;
    in_ch.to_box = '0;
    in_ch.kind = '0;
    in_ch.offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.num_kinds = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    table_clear();
    mirror_kinds = 1;
    plan_kinds = 1;

    // Directed part with one kind per box: empty table, bad kinds, duplicates,
    // moves both ways and within a box, missing molecule, unused codes, clear.
    push_op(FN_READ, 0, 0, 0, 0, 0);
    push_op(FN_COUNT, 0, 0, 0, 0, 0);
    push_op(FN_COUNT, 0, 0, 0, KIND_MAX - 1, 0);
    push_op(FN_APPEND, MOL_MAX - 1, 1, 0, 0, MOL_MAX - 1);
    push_op(FN_APPEND, 0, 0, 1, 0, 0);
    push_op(FN_APPEND, 'h2AA, 0, 0, 0, 'h155);
    push_op(FN_APPEND, 'h155, 0, 1, 0, 'h2AA);
    push_op(FN_APPEND, 0, 0, 0, 0, 0);
    push_op(FN_MOVE, 'h155, 0, 1, 0, 0);
    push_op(FN_MOVE, 'h155, 1, 0, 0, 0);
    push_op(FN_MOVE, 0, 0, 0, 0, 0);
    push_op(FN_MOVE, 0, 0, 1, 0, 0);
    push_op(FN_MOVE, 5, 0, 1, 0, 0);
    push_op(FN_MOVE, 0, 0, 1, 4, 0);
    push_op(FN_APPEND, 7, 0, 0, 1, 0);
    push_op(FN_READ, 0, 0, 0, KIND_MAX - 1, 0);
    push_op(FN_READ, 0, 0, 0, 0, 2);
    push_op(FN_READ, 0, 1, 0, 0, 1);
    push_op(FN_READ, 0, 1, 0, 0, MOL_MAX - 1);
    push_op(FN_COUNT, 0, 1, 0, 0, 0);
    for (int f = FN_CLEAR + 1; f < (1 << FUNC_W); f++) push_op(f, 0, 0, 0, 0, 0);
    push_op(FN_CLEAR, 0, 0, 0, 0, 0);
    push_op(FN_COUNT, 0, 1, 0, 0, 0);

    // Random phases over a spread of kind settings, saturating writes included.
    kinds_plan = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd9, 4'd1, 4'd0};
    kinds_plan[7] = $urandom_range(KIND_MAX - 1, 2);
    foreach (kinds_plan[p]) begin
      push_kinds(kinds_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) push_drain();
        push_random_op();
      end
    end

    // Full table: fill the last section so nothing needs shifting, then probe it.
    push_kinds(2);
    for (int i = 0; i < MOL_MAX; i++)
      push_op(FN_APPEND, $urandom_range(MOL_MAX - 1), 1, 0, 1, $urandom_range(MOL_MAX - 1));
    push_op(FN_APPEND, $urandom_range(MOL_MAX - 1), 1, 0, 1, 0);
    push_op(FN_APPEND, $urandom_range(MOL_MAX - 1), 0, 1, 0, 0);
    push_op(FN_COUNT, 0, 1, 0, 1, 0);
    push_op(FN_COUNT, 0, 0, 0, 0, 0);
    push_op(FN_READ, 0, 1, 0, 0, 0);
    push_op(FN_READ, 0, 1, 0, 0, MOL_MAX - 1);
    push_op(FN_READ, 0, 0, 0, 0, 0);
    for (int i = 0; i < 30; i++)
      push_op(FN_READ, $urandom_range(MOL_MAX - 1), 1, $urandom_range(BOX_COUNT - 1),
              $urandom_range(KIND_MAX - 1), $urandom_range(MOL_MAX - 1));
    for (int i = 0; i < 4; i++) begin
      pick = $urandom_range(placed_q.size() - 1);
      push_op(FN_MOVE, placed_q[pick].id, placed_q[pick].bx, 0, placed_q[pick].kd, 0);
    end
    push_op(FN_COUNT, 0, 0, 0, 1, 0);
    push_op(FN_CLEAR, 0, 0, 0, 0, 0);

    push_kinds(4);
    for (int i = 0; i < 30; i++) push_random_op();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent != n_planned) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Driver: presents queued operations and kind writes, predicting each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      cfg_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_op.func = in_ch.func;
        taken_op.mol_id = in_ch.mol_id;
        taken_op.box = in_ch.box;
        taken_op.to_box = in_ch.to_box;
        taken_op.kind = in_ch.kind;
        taken_op.offset = in_ch.offset;
        expected_results.push_back(table_apply(taken_op));
        n_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) table_set_kinds(cfg_ch.num_kinds);

      // Hold the offered item until its transfer; otherwise pick the next step.
      if (!((in_ch.valid && !in_ch.ready) || (cfg_ch.valid && !cfg_ch.ready))) begin
        give_op = 1'b0;
        give_cfg = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_steps.size() != 0) begin
          head_step = pending_steps[0];
          case (head_step.sel)
            STEP_OP: begin
              give_op = 1'b1;
              void'(pending_steps.pop_front());
              gap_left = pick_gap((n_sent / 50) % 5 == 2);
            end
            STEP_KINDS: begin
              if (expected_results.size() == 0) begin
                give_cfg = 1'b1;
                void'(pending_steps.pop_front());
                gap_left = pick_gap(1'b0);
              end
            end
            default: begin
              if (expected_results.size() == 0) void'(pending_steps.pop_front());
            end
          endcase
        end
        in_ch.valid <= give_op;
        cfg_ch.valid <= give_cfg;
        if (give_op) begin
          in_ch.func <= head_step.op.func;
          in_ch.mol_id <= head_step.op.mol_id;
          in_ch.box <= head_step.op.box;
          in_ch.to_box <= head_step.op.to_box;
          in_ch.kind <= head_step.op.kind;
          in_ch.offset <= head_step.op.offset;
        end
        if (give_cfg) cfg_ch.num_kinds <= head_step.kinds;
      end
    end
  end

  // Monitor: checks each result transfer and throttles ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d", out_ch.status);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("found_mol", want.found_mol, out_ch.found_mol);
          check_field("kind_count", want.kind_count, out_ch.kind_count);
          check_field("box_count", want.box_count, out_ch.box_count);
        end
        // Two long hold-offs let the block back up into its input.
        if (n_seen == 80 || n_seen == 500) stall_left = HOLD_CYCLES;
        else stall_left = pick_gap((n_seen / 50) % 5 == 4);
      end else if (stall_left == 0 && !out_ch.valid && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(6, 1);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

### partitioned_membership_table.f
+incdir+hdl
hdl/pmt_pkg.sv
hdl/pmt_if.sv
hdl/pmt_sec_table.sv
hdl/partitioned_membership_table.sv
sim/tb_partitioned_membership_table.sv
